// ===== sv/gfba_pkg.sv =====
// shared constants and types for the gyro fifo batch averager
package gfba_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int GAIN_W         = 16;
    localparam int AVG_W          = 32;
    localparam int KEPT_W         = 6;
    localparam int MAX_BATCH_DEF  = 32;

    localparam int IN_DATA_W      = 48;
    localparam int OUT_DATA_W     = 104;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd573;
    localparam logic signed [SAMPLE_W-1:0] SENT_NEG   = 16'sh8001;
    localparam logic signed [SAMPLE_W-1:0] SENT_POS   = 16'sh7fff;

    // register word index
    localparam logic REG_RATE_GAIN = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } gfba_state_t;

endpackage

// ===== sv/gyro_fifo_batch_averager.sv =====
// top level of the gyro fifo batch averager
//
// Three-axis gyro samples come in one transfer each; tuser marks the first
// sample of a fifo drain and tlast the last. Kept samples are summed per axis
// in the cycle they are taken, so a sample that does not close a batch leaves
// the block ready for the next one. A closing sample starts the averaging
// sequence: for each axis the shared multiplier (|sum| times rate_gain) and
// then a shared restoring divider, one quotient bit per cycle, then a finish
// state that moves the result into the output register when that register is
// free. A batch with no kept sample skips the multiplier and divider and goes
// straight to the finish state.
// s_axis_tready stays low while a batch is being averaged, and also while a
// finished result cannot yet move into an occupied output register.
// rate_gain is written through the apb port and should only change while the
// block is idle.
module gyro_fifo_batch_averager #(
    parameter int MAX_BATCH = gfba_pkg::MAX_BATCH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // sample stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gfba_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // x_rate, y_rate, z_rate
    input  logic                               s_axis_tuser,  // first_of_batch
    input  logic                               s_axis_tlast,  // last_of_batch
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gfba_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // avg_x, avg_y, avg_z,
                                                              // kept_samples, zero pad
    output logic                               m_axis_tuser,  // batch_valid
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gfba_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gfba_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gfba_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);
    import gfba_pkg::*;

    // sum width covers MAX_BATCH full-scale samples
    localparam int LB     = $clog2(MAX_BATCH);
    localparam int SUM_W  = SAMPLE_W + LB;
    localparam int CNT_W  = $clog2(MAX_BATCH + 1);
    localparam int PROD_W = SUM_W + GAIN_W;
    localparam int STEP_W = $clog2(PROD_W + 1);
    localparam int PAD_W  = OUT_DATA_W - 3 * AVG_W - KEPT_W;

    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic signed [SAMPLE_W-1:0] samp_t;
    typedef logic signed [AVG_W-1:0]    avg_t;

    gfba_state_t state_reg, state_next;

    // batch state
    sum_t              sum_reg  [3];
    sum_t              sum_next [3];
    logic [CNT_W-1:0]  kept_reg, kept_next;
    samp_t             prev_reg [3];
    samp_t             prev_next[3];
    logic [GAIN_W-1:0] gain_reg, gain_next;

    // averaging sequence
    logic [1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              neg_reg, neg_next;
    avg_t              avg_reg [3];
    avg_t              avg_next[3];

    // output register
    logic              m_valid_reg, m_valid_next;
    avg_t              out_avg_reg [3];
    avg_t              out_avg_next[3];
    logic [KEPT_W-1:0] out_kept_reg, out_kept_next;
    logic              out_bv_reg, out_bv_next;

    samp_t             smp[3];
    logic              in_xfer;
    logic              cfg_wr;
    logic              dup;
    logic              keep;
    sum_t              base_sum[3];
    logic [CNT_W-1:0]  base_kept;
    sum_t              cur_sum;
    logic              cur_neg;
    logic [SUM_W-1:0]  cur_mag;
    logic [PROD_W-1:0] prod;
    logic [CNT_W:0]    rem_sh;
    logic              div_ge;
    logic [AVG_W-1:0]  quo_lo;

    assign smp[0] = s_axis_tdata[15:0];
    assign smp[1] = s_axis_tdata[31:16];
    assign smp[2] = s_axis_tdata[47:32];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_wr        = psel && penable && pwrite && pready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE_GAIN) ? APB_DATA_W'(gain_reg) : '0;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_bv_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_kept_reg,
                            out_avg_reg[2], out_avg_reg[1], out_avg_reg[0]};

    // first mark restarts the batch and runs the duplicate check
    assign dup = (smp[0] == prev_reg[0]) && (smp[1] == prev_reg[1])
              && (smp[2] == prev_reg[2]);
    assign base_kept = s_axis_tuser ? '0 : kept_reg;
    assign keep = !(s_axis_tuser && dup) && (base_kept < CNT_W'(MAX_BATCH));

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            base_sum[i] = s_axis_tuser ? '0 : sum_reg[i];
        end
    end

    // shared multiplier: magnitude of the selected axis sum times gain
    always_comb
    begin
        case (axis_reg)
            2'd0:    cur_sum = sum_reg[0];
            2'd1:    cur_sum = sum_reg[1];
            default: cur_sum = sum_reg[2];
        endcase
    end
    assign cur_neg = cur_sum[SUM_W-1];
    assign cur_mag = cur_neg ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
    assign prod    = PROD_W'(cur_mag) * PROD_W'(gain_reg);

    // shared divider: one restoring step per cycle
    assign rem_sh = {rem_reg, quo_reg[PROD_W-1]};
    assign div_ge = rem_sh >= {1'b0, kept_reg};
    assign quo_lo = quo_next[AVG_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        kept_next     = kept_reg;
        gain_next     = gain_reg;
        axis_next     = axis_reg;
        step_next     = step_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        m_valid_next  = m_valid_reg;
        out_kept_next = out_kept_reg;
        out_bv_next   = out_bv_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i]     = sum_reg[i];
            prev_next[i]    = prev_reg[i];
            avg_next[i]     = avg_reg[i];
            out_avg_next[i] = out_avg_reg[i];
        end

        if (cfg_wr && paddr[2] == REG_RATE_GAIN)
        begin
            gain_next = pwdata[GAIN_W-1:0];
        end

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_next[i] = keep ? sum_t'(base_sum[i] + sum_t'(smp[i]))
                                           : base_sum[i];
                    end
                    kept_next = keep ? CNT_W'(base_kept + 1'b1) : base_kept;
                    if (s_axis_tlast)
                    begin
                        axis_next = 2'd0;
                        if (kept_next == '0)
                        begin
                            // empty batch: zero result, sentinel for the next check
                            prev_next[0] = SENT_NEG;
                            prev_next[1] = SENT_POS;
                            prev_next[2] = SENT_NEG;
                            for (int i = 0; i < 3; i++)
                            begin
                                avg_next[i] = '0;
                            end
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                prev_next[i] = smp[i];
                            end
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                quo_next   = prod;
                neg_next   = cur_neg;
                rem_next   = '0;
                step_next  = STEP_W'(PROD_W);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                quo_next  = {quo_reg[PROD_W-2:0], div_ge};
                rem_next  = div_ge ? CNT_W'(rem_sh - {1'b0, kept_reg}) : CNT_W'(rem_sh);
                step_next = step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    avg_next[axis_reg] = neg_reg ? avg_t'(-quo_lo) : avg_t'(quo_lo);
                    if (axis_reg == 2'd2)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_FIN:
            begin
                // wait for the output register to free up
                if (!m_valid_reg || m_axis_tready)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        out_avg_next[i] = avg_reg[i];
                        sum_next[i]     = '0;
                    end
                    out_kept_next = KEPT_W'(kept_reg);
                    out_bv_next   = (kept_reg != '0);
                    m_valid_next  = 1'b1;
                    kept_next     = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kept_reg    <= '0;
            gain_reg    <= GAIN_RESET;
            m_valid_reg <= 1'b0;
            axis_reg    <= 2'd0;
            step_reg    <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= '0;
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            kept_reg    <= kept_next;
            gain_reg    <= gain_next;
            m_valid_reg <= m_valid_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= sum_next[i];
                prev_reg[i] <= prev_next[i];
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_kept_reg <= out_kept_next;
        out_bv_reg   <= out_bv_next;
        for (int i = 0; i < 3; i++)
        begin
            avg_reg[i]     <= avg_next[i];
            out_avg_reg[i] <= out_avg_next[i];
        end
    end

    // kept count never passes the batch limit
    a_kept_limit: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= CNT_W'(MAX_BATCH))
        else $error("kept count above batch limit");

    // the divider never runs with a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_DIV) |-> kept_reg != '0)
        else $error("averaging with no kept samples");

    // an invalid batch carries a zero count and zero averages
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid batch with nonzero payload");

    // a result appears only when the sequence finishes
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_FIN)
        else $error("result raised outside finish");

endmodule

// ===== tb/tb_gyro_fifo_batch_averager.sv =====
// self-checking testbench for the gyro fifo batch averager
`timescale 1ns / 1ps

module tb_gyro_fifo_batch_averager;
    import gfba_pkg::*;

    // margin for the longest averaging sequence: three axes through multiplier and divider, then finish
    localparam int DRAIN_CYCLES = 130;
    localparam int TIMEOUT_NS   = 4_000_000;
    localparam int PHASE_ITEMS  = 250;

    // byte addresses of the register file; the spare word has no register behind it
    localparam logic [APB_ADDR_W-1:0] GAIN_ADDR  = {REG_RATE_GAIN, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_RATE_GAIN, 2'b00};

    logic clk;
    logic rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // x_rate, y_rate, z_rate
    logic                   s_axis_tuser = 1'b0; // first_of_batch
    logic                   s_axis_tlast = 1'b0; // last_of_batch

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;        // avg_x, avg_y, avg_z, kept_samples, pad
    logic                   m_axis_tuser;        // batch_valid

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // chance in percent that either side idles in a given cycle
    int unsigned idle_pct = 11;

    typedef struct {
        logic signed [AVG_W-1:0] avg [3];
        logic [KEPT_W-1:0]       kept;
        logic                    valid;
    } batch_average_t;

    // running batch state and the queue of averages still owed by the block
    class rate_average_board;
        int unsigned             gain;
        longint                  axis_sum [3];
        int unsigned             kept;
        logic signed [SAMPLE_W-1:0] prev_sample [3];
        logic signed [SAMPLE_W-1:0] cur_last [3];
        batch_average_t          pending_averages [$];
        int unsigned             mismatches;

        function new();
            gain = GAIN_RESET;
            kept = 0;
            mismatches = 0;
            for (int i = 0; i < 3; i++)
            begin
                axis_sum[i] = 0;
                prev_sample[i] = '0;
                cur_last[i] = '0;
            end
        endfunction

        function void report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            mismatches++;
        endfunction

        function int pending();
            return pending_averages.size();
        endfunction

        function void clear_batch();
            for (int i = 0; i < 3; i++)
                axis_sum[i] = 0;
            kept = 0;
        endfunction

        // called for each accepted sample transfer
        function void take_sample(logic signed [SAMPLE_W-1:0] s [3], logic first, logic last);
            bit keep;
            batch_average_t res;
            longint q;
            keep = 1'b1;
            if (first)
            begin
                clear_batch();
                // repeat of the previous drain's last sample
                if (s[0] == prev_sample[0] && s[1] == prev_sample[1] &&
                    s[2] == prev_sample[2])
                    keep = 1'b0;
            end
            if (kept >= MAX_BATCH_DEF)
                keep = 1'b0;
            if (keep)
            begin
                for (int i = 0; i < 3; i++)
                    axis_sum[i] += longint'(s[i]);
                kept++;
            end
            for (int i = 0; i < 3; i++)
                cur_last[i] = s[i];
            if (!last)
                return;
            if (kept == 0)
            begin
                for (int i = 0; i < 3; i++)
                    res.avg[i] = '0;
                res.kept = '0;
                res.valid = 1'b0;
                prev_sample[0] = SENT_NEG;
                prev_sample[1] = SENT_POS;
                prev_sample[2] = SENT_NEG;
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q = (axis_sum[i] * longint'(gain)) / longint'(kept);
                    res.avg[i] = q[AVG_W-1:0];
                    prev_sample[i] = cur_last[i];
                end
                res.kept = kept[KEPT_W-1:0];
                res.valid = 1'b1;
            end
            pending_averages.push_back(res);
            clear_batch();
        endfunction

        // called for each accepted result transfer
        function void check_average(logic [OUT_DATA_W-1:0] data, logic user);
            batch_average_t e;
            logic signed [AVG_W-1:0] got;
            if (pending_averages.size() == 0)
            begin
                report("result transfer with no batch average expected");
                return;
            end
            e = pending_averages.pop_front();
            for (int i = 0; i < 3; i++)
            begin
                got = data[i*AVG_W +: AVG_W];
                if (got !== e.avg[i])
                    report($sformatf("avg axis %0d: got %0d, want %0d", i, got, e.avg[i]));
            end
            if (data[3*AVG_W +: KEPT_W] !== e.kept)
                report($sformatf("kept_samples: got %0d, want %0d",
                                 data[3*AVG_W +: KEPT_W], e.kept));
            if (user !== e.valid)
                report($sformatf("batch_valid: got %b, want %b", user, e.valid));
        endfunction
    endclass

    rate_average_board board = new();

    gyro_fifo_batch_averager dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result side: check each transfer, then pick the next ready value
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_average(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // one sample transfer; returns right after the accepting edge
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z,
                               input logic first, input logic last);
        logic signed [SAMPLE_W-1:0] s [3];
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        s[0] = x;
        s[1] = y;
        s[2] = z;
        board.take_sample(s, first, last);
    endtask

    task automatic stop_samples();
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                            output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every owed average is out and the divider has gone quiet
    task automatic settle();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic check_gain_readback();
        logic [APB_DATA_W-1:0] rd;
        apb_read(GAIN_ADDR, rd);
        if (rd !== APB_DATA_W'(board.gain))
            board.report($sformatf("rate_gain readback: got %0d, want %0d", rd, board.gain));
    endtask

    // new gain, plus a write to the unused word that must change nothing
    task automatic set_gain(input logic [GAIN_W-1:0] value);
        settle();
        apb_write(GAIN_ADDR, APB_DATA_W'(value));
        board.gain = value;
        apb_write(SPARE_ADDR, $urandom);
        check_gain_readback();
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_rate();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return SAMPLE_W'($signed($urandom_range(20)) - 10);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // random traffic: mostly whole drains, some cut short, some loose samples
    task automatic run_drains(input int n_items);
        int sent;
        int len;
        int pick;
        logic signed [SAMPLE_W-1:0] x, y, z;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 85)
            begin
                // long drains can run past the batch limit on the kept count
                len = ($urandom_range(99) < 5) ? $urandom_range(30, 40) : $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                begin
                    x = rand_rate();
                    y = rand_rate();
                    z = rand_rate();
                    if (i == 0 && $urandom_range(99) < 20)
                    begin
                        x = board.prev_sample[0];
                        y = board.prev_sample[1];
                        z = board.prev_sample[2];
                    end
                    send_sample(x, y, z, i == 0, i == len - 1);
                end
                sent += len;
            end
            else if (pick < 93)
            begin
                // drain left open; a later first mark throws it away, a later last mark alone closes it
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    send_sample(rand_rate(), rand_rate(), rand_rate(), i == 0, 1'b0);
                sent += len;
            end
            else
            begin
                send_sample(rand_rate(), rand_rate(), rand_rate(),
                            1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end
        end
        // close any open drain before the phase ends
        send_sample(rand_rate(), rand_rate(), rand_rate(), 1'b0, 1'b1);
        stop_samples();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_gain_readback();

        // zero sample right after reset matches the cleared previous sample: empty batch
        send_sample(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1);
        // the sentinel left by the empty batch is itself dropped
        send_sample(SENT_NEG, SENT_POS, SENT_NEG, 1'b1, 1'b1);
        // full-scale swing on a two-sample drain
        send_sample(16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b0);
        send_sample(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b1);
        // sample without a first mark after a finished batch opens a new one
        send_sample(16'sd1, 16'sd2, 16'sd3, 1'b0, 1'b1);
        // first mark in the middle of a drain restarts it
        send_sample(16'sd100, -16'sd100, 16'sd50, 1'b1, 1'b0);
        send_sample(16'sd200, 16'sd300, -16'sd400, 1'b0, 1'b0);
        send_sample(16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b0);
        send_sample(16'sd7, 16'sd7, 16'sd7, 1'b0, 1'b1);
        // repeat of the last sample is dropped, the next one averaged alone
        send_sample(16'sd7, 16'sd7, 16'sd7, 1'b1, 1'b0);
        send_sample(16'sd1, -16'sd1, 16'sd1, 1'b0, 1'b1);
        // negative average truncates toward zero
        send_sample(-16'sd3, -16'sd5, 16'sd1, 1'b1, 1'b0);
        send_sample(-16'sd4, 16'sd0, -16'sd2, 1'b0, 1'b1);
        // single-sample extremes
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b1);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
        // partial match on the first sample is kept
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7ffe, 1'b1, 1'b1);
        stop_samples();

        run_drains(PHASE_ITEMS);

        set_gain(16'd0);
        run_drains(PHASE_ITEMS);

        // full gain with both sides streaming back to back
        set_gain(16'hffff);
        idle_pct = 0;
        run_drains(PHASE_ITEMS);
        idle_pct = 11;

        set_gain(16'd1);
        run_drains(PHASE_ITEMS);

        set_gain(GAIN_W'($urandom));
        run_drains(PHASE_ITEMS);

        settle();
        if (board.pending() != 0)
            board.report("batch averages still owed at the end");
        if (board.mismatches == 0)
            $display("tb_gyro_fifo_batch_averager passed");
        else
            $display("tb_gyro_fifo_batch_averager failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t ns: timeout", $time);
        $display("tb_gyro_fifo_batch_averager failed");
        $finish;
    end

endmodule
